[rtl/cvh_pkg.sv]
// Shared constants for the convex hull block.
// Used by cvh_front, cvh_back and convex_hull_graham_scan.
package cvh_pkg;
  localparam int unsigned XY_W        = 16;  // coordinate width on the stream
  localparam int unsigned TDATA_W     = 32;  // x in the low half, y in the high half
  localparam int unsigned SMALL_SET   = 3;   // sets this small are echoed as they came
  localparam int unsigned QUEUE_DEPTH = 4;   // words buffered between front and back
endpackage

[rtl/cvh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cvh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/cvh_front.sv]
// Input side: accepts point words, cuts coordinates to COORD_BITS and queues them.
// Depends on cvh_pkg.
module cvh_front
  import cvh_pkg::*;
#(
  parameter int unsigned CW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [TDATA_W-1:0]   s_tdata_i,
  input  logic                 s_tlast_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output logic signed [CW-1:0] q_x_o,
  output logic signed [CW-1:0] q_y_o,
  output logic                 q_last_o
);
  localparam int unsigned QP_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [CW-1:0] x_q [QUEUE_DEPTH];
  logic signed [CW-1:0] y_q [QUEUE_DEPTH];
  logic                 last_q [QUEUE_DEPTH];
  logic [QP_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0]      cnt_q;
  logic                 push, pop;
  logic signed [CW-1:0] x_in, y_in;

  // keep the low COORD_BITS of each field as a two's complement value
  assign x_in = CW'(s_tdata_i[XY_W-1:0]);
  assign y_in = CW'(s_tdata_i[2*XY_W-1:XY_W]);

  assign s_tready_o = (cnt_q != QC_W'(QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign push       = s_tvalid_i && s_tready_o;
  assign pop        = q_valid_o && q_ready_i;
  assign q_x_o      = x_q[rd_ptr_q];
  assign q_y_o      = y_q[rd_ptr_q];
  assign q_last_o   = last_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      x_q[wr_ptr_q]    <= x_in;
      y_q[wr_ptr_q]    <= y_in;
      last_q[wr_ptr_q] <= s_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

[rtl/cvh_back.sv]
// Hull engine: stores points, tracks the pivot, ranks by angle, scans and emits.
// Depends on cvh_pkg and cvh_ram.
module cvh_back
  import cvh_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned CW         = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  logic signed [CW-1:0] q_x_i,
  input  logic signed [CW-1:0] q_y_i,
  input  logic                 q_last_i,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [XY_W-1:0]      m_x_o,
  output logic [XY_W-1:0]      m_y_o,
  output logic                 m_last_o,
  output logic                 m_ovf_o
);
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned PW    = 2 * CW;
  localparam int unsigned DW    = CW + 1;
  localparam int unsigned MW    = 2 * DW;
  localparam int unsigned SW    = MW + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_R_RDI, S_R_WTI, S_R_RUN, S_R_WR, S_S_INIT, S_F_ORD,
    S_F_PT, S_F_WT, S_CHK, S_X1, S_X2, S_POPWT, S_PUSH, S_EM_PUT
  } state_e;

  // S_EM_RD folded into a flag: emit reads are issued from the S_EM_PUT state below
  state_e state_q;
  logic   em_rd_q;

  logic [CNT_W-1:0]     cnt_q, i_q, j_q, rank_q, depth_q, k_q, len_q;
  logic                 ovf_q, from_stk_q;
  logic [IDX_W-1:0]     piv_q;
  logic signed [CW-1:0] px_q, py_q, tx_q, ty_q, sx_q, sy_q, cx_q, cy_q;
  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, d1x_q, d1y_q, d2x_q, d2y_q;
  logic signed [MW-1:0] cr1_q, cr2_q, db1_q, db2_q, da1_q, da2_q, xm1_q, xm2_q;
  logic                 v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]     j1_q, j2_q, j3_q;
  logic                 ov_q, olast_q, oovf_q;
  logic [XY_W-1:0]      ox_q, oy_q;

  logic             pt_we, pt_re, ord_we, ord_re, stk_we, stk_re;
  logic [IDX_W-1:0] pt_waddr, pt_raddr, ord_waddr, stk_waddr, stk_raddr;
  logic [IDX_W-1:0] ord_wdata, ord_rdata;
  logic [PW-1:0]    pt_wdata, pt_rdata, stk_wdata, stk_rdata, em_data;
  logic             issue, hit, out_load, em_last, turn_ccw, is_less;
  logic signed [CW-1:0] rx, ry;
  logic signed [SW-1:0] cr, db, da, xc;

  assign rx = pt_rdata[CW-1:0];
  assign ry = pt_rdata[PW-1:CW];
  assign is_less = (q_y_i < py_q) || ((q_y_i == py_q) && (q_x_i < px_q));

  assign q_ready_o = (state_q == S_LOAD);
  assign issue     = (state_q == S_R_RUN) && (j_q < cnt_q);

  // angle order around the pivot: j ranks before i
  assign cr  = SW'(cr1_q) - SW'(cr2_q);
  assign db  = SW'(db1_q) + SW'(db2_q);
  assign da  = SW'(da1_q) + SW'(da2_q);
  assign hit = v3_q && (j3_q != i_q[IDX_W-1:0]) && (j3_q != piv_q) &&
               ((cr > 0) || ((cr == 0) &&
               ((db < da) || ((db == da) && (j3_q < i_q[IDX_W-1:0])))));

  assign xc       = SW'(xm1_q) - SW'(xm2_q);
  assign turn_ccw = (xc > 0);

  assign em_data  = from_stk_q ? stk_rdata : pt_rdata;
  assign em_last  = (k_q + 1'b1 == len_q);
  assign out_load = (state_q == S_EM_PUT) && !em_rd_q && (!ov_q || m_tready_i);

  always_comb begin
    pt_we     = (state_q == S_LOAD) && q_valid_i && (cnt_q != CNT_W'(MAX_POINTS));
    pt_waddr  = cnt_q[IDX_W-1:0];
    pt_wdata  = {q_y_i, q_x_i};
    pt_re     = 1'b0;
    pt_raddr  = i_q[IDX_W-1:0];
    ord_we    = 1'b0;
    ord_waddr = rank_q[IDX_W-1:0];
    ord_wdata = i_q[IDX_W-1:0];
    ord_re    = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = depth_q[IDX_W-1:0];
    stk_wdata = {cy_q, cx_q};
    stk_re    = 1'b0;
    stk_raddr = IDX_W'(depth_q - CNT_W'(3));
    unique case (state_q)
      S_START: begin
        ord_we    = (cnt_q > CNT_W'(SMALL_SET));
        ord_waddr = '0;
        ord_wdata = piv_q;
      end
      S_R_RDI: pt_re = (i_q != cnt_q) && (i_q[IDX_W-1:0] != piv_q);
      S_R_RUN: begin
        pt_re    = issue;
        pt_raddr = j_q[IDX_W-1:0];
      end
      S_R_WR:  ord_we = 1'b1;
      S_S_INIT: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = {py_q, px_q};
      end
      S_F_ORD: ord_re = 1'b1;
      S_F_PT: begin
        pt_re    = 1'b1;
        pt_raddr = ord_rdata;
      end
      S_X2:    stk_re = !turn_ccw && (depth_q >= CNT_W'(3));
      S_PUSH:  stk_we = 1'b1;
      S_EM_PUT: begin
        pt_re     = em_rd_q && !from_stk_q;
        stk_re    = em_rd_q && from_stk_q;
        pt_raddr  = k_q[IDX_W-1:0];
        stk_raddr = k_q[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      em_rd_q    <= 1'b0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      piv_q      <= '0;
      px_q       <= '0;
      py_q       <= '0;
      i_q        <= '0;
      j_q        <= '0;
      rank_q     <= '0;
      depth_q    <= '0;
      k_q        <= '0;
      len_q      <= '0;
      from_stk_q <= 1'b0;
      tx_q       <= '0;
      ty_q       <= '0;
      sx_q       <= '0;
      sy_q       <= '0;
      cx_q       <= '0;
      cy_q       <= '0;
      ax_q       <= '0;
      ay_q       <= '0;
      bx_q       <= '0;
      by_q       <= '0;
      d1x_q      <= '0;
      d1y_q      <= '0;
      d2x_q      <= '0;
      d2y_q      <= '0;
      cr1_q      <= '0;
      cr2_q      <= '0;
      db1_q      <= '0;
      db2_q      <= '0;
      da1_q      <= '0;
      da2_q      <= '0;
      xm1_q      <= '0;
      xm2_q      <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      j1_q       <= '0;
      j2_q       <= '0;
      j3_q       <= '0;
      ov_q       <= 1'b0;
      ox_q       <= '0;
      oy_q       <= '0;
      olast_q    <= 1'b0;
      oovf_q     <= 1'b0;
    end else begin
      // ranking pipeline: read, offset from pivot, multiply, compare
      v1_q  <= issue;
      j1_q  <= j_q[IDX_W-1:0];
      v2_q  <= v1_q;
      j2_q  <= j1_q;
      bx_q  <= DW'(rx) - DW'(px_q);
      by_q  <= DW'(ry) - DW'(py_q);
      v3_q  <= v2_q;
      j3_q  <= j2_q;
      cr1_q <= MW'(bx_q) * MW'(ay_q);
      cr2_q <= MW'(by_q) * MW'(ax_q);
      db1_q <= MW'(bx_q) * MW'(bx_q);
      db2_q <= MW'(by_q) * MW'(by_q);
      da1_q <= MW'(ax_q) * MW'(ax_q);
      da2_q <= MW'(ay_q) * MW'(ay_q);
      if (hit) rank_q <= rank_q + 1'b1;

      if (out_load) begin
        ov_q    <= 1'b1;
        ox_q    <= XY_W'(signed'(em_data[CW-1:0]));
        oy_q    <= XY_W'(signed'(em_data[PW-1:CW]));
        olast_q <= em_last;
        oovf_q  <= ovf_q;
      end else if (m_tready_i) begin
        ov_q <= 1'b0;
      end

      unique case (state_q)
        S_LOAD: begin
          if (q_valid_i) begin
            if (pt_we) begin
              cnt_q <= cnt_q + 1'b1;
              if (cnt_q == '0 || is_less) begin
                piv_q <= cnt_q[IDX_W-1:0];
                px_q  <= q_x_i;
                py_q  <= q_y_i;
              end
            end else begin
              ovf_q <= 1'b1;
            end
            if (q_last_i) state_q <= S_START;
          end
        end
        S_START: begin
          if (cnt_q <= CNT_W'(SMALL_SET)) begin
            from_stk_q <= 1'b0;
            len_q      <= cnt_q;
            k_q        <= '0;
            em_rd_q    <= 1'b1;
            state_q    <= S_EM_PUT;
          end else begin
            i_q     <= '0;
            state_q <= S_R_RDI;
          end
        end
        S_R_RDI: begin
          if (i_q == cnt_q) begin
            state_q <= S_S_INIT;
          end else if (i_q[IDX_W-1:0] == piv_q) begin
            i_q <= i_q + 1'b1;
          end else begin
            state_q <= S_R_WTI;
          end
        end
        S_R_WTI: begin
          ax_q    <= DW'(rx) - DW'(px_q);
          ay_q    <= DW'(ry) - DW'(py_q);
          j_q     <= '0;
          rank_q  <= CNT_W'(1);
          state_q <= S_R_RUN;
        end
        S_R_RUN: begin
          if (issue) begin
            j_q <= j_q + 1'b1;
          end else if (!v1_q && !v2_q && !v3_q) begin
            state_q <= S_R_WR;
          end
        end
        S_R_WR: begin
          i_q     <= i_q + 1'b1;
          state_q <= S_R_RDI;
        end
        S_S_INIT: begin
          tx_q    <= px_q;
          ty_q    <= py_q;
          depth_q <= CNT_W'(1);
          i_q     <= CNT_W'(1);
          state_q <= S_F_ORD;
        end
        S_F_ORD: state_q <= S_F_PT;
        S_F_PT:  state_q <= S_F_WT;
        S_F_WT: begin
          cx_q    <= rx;
          cy_q    <= ry;
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (depth_q < CNT_W'(2)) begin
            state_q <= S_PUSH;
          end else begin
            d1x_q   <= DW'(tx_q) - DW'(sx_q);
            d1y_q   <= DW'(ty_q) - DW'(sy_q);
            d2x_q   <= DW'(cx_q) - DW'(sx_q);
            d2y_q   <= DW'(cy_q) - DW'(sy_q);
            state_q <= S_X1;
          end
        end
        S_X1: begin
          xm1_q   <= MW'(d1x_q) * MW'(d2y_q);
          xm2_q   <= MW'(d1y_q) * MW'(d2x_q);
          state_q <= S_X2;
        end
        S_X2: begin
          if (turn_ccw) begin
            state_q <= S_PUSH;
          end else begin
            // drop the top: second becomes top, refetch the new second
            depth_q <= depth_q - 1'b1;
            tx_q    <= sx_q;
            ty_q    <= sy_q;
            state_q <= (depth_q >= CNT_W'(3)) ? S_POPWT : S_CHK;
          end
        end
        S_POPWT: begin
          sx_q    <= stk_rdata[CW-1:0];
          sy_q    <= stk_rdata[PW-1:CW];
          state_q <= S_CHK;
        end
        S_PUSH: begin
          sx_q    <= tx_q;
          sy_q    <= ty_q;
          tx_q    <= cx_q;
          ty_q    <= cy_q;
          depth_q <= depth_q + 1'b1;
          i_q     <= i_q + 1'b1;
          if (i_q + 1'b1 == cnt_q) begin
            from_stk_q <= 1'b1;
            len_q      <= depth_q + 1'b1;
            k_q        <= '0;
            em_rd_q    <= 1'b1;
            state_q    <= S_EM_PUT;
          end else begin
            state_q <= S_F_ORD;
          end
        end
        S_EM_PUT: begin
          if (em_rd_q) begin
            em_rd_q <= 1'b0;
          end else if (out_load) begin
            k_q <= k_q + 1'b1;
            if (em_last) begin
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              em_rd_q <= 1'b1;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_x_o      = ox_q;
  assign m_y_o      = oy_q;
  assign m_last_o   = olast_q;
  assign m_ovf_o    = oovf_q;

  cvh_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .re_i    (pt_re),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  cvh_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (i_q[IDX_W-1:0]),
    .rdata_o (ord_rdata)
  );

  cvh_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> (depth_q < cnt_q))
    else $error("hull depth exceeds point count");
  a_rank_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (!v1_q && !v2_q && !v3_q))
    else $error("ranking pipeline busy while loading");
  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && em_last) |=> (cnt_q == '0 && !ovf_q))
    else $error("set not cleared after last vertex");
  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_R_WR) |-> (rank_q != '0 && rank_q < cnt_q))
    else $error("angle rank out of range");
`endif
endmodule

[rtl/convex_hull_graham_scan.sv]
// Channel   Dir  tdata                         tlast        tuser
// s_axis    in   [15:0] x, [31:16] y          final point  -
// m_axis    out  [15:0] hull x, [31:16] hull y last vertex  overflow
//
// Points load at one per cycle, while the 4-word queue has room. After the final point
// the engine ranks N points with a pipelined cross-product compare, scans the hull
// over a stack of vertices, and emits the hull, reading each vertex from RAM before
// it is presented. Sets of three or fewer points are echoed directly.
// Reset is asynchronous, active low. The output register holds a vertex while
// m_axis_tready_i is low; the input side stalls only when the queue is full.
// Top level of the convex hull block; depends on cvh_pkg, cvh_front, cvh_back.
module convex_hull_graham_scan
  import cvh_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,   // [15:0] point_x, [31:16] point_y
  input  logic               s_axis_tlast_i,   // final_point
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,   // [15:0] hull_x, [31:16] hull_y
  output logic               m_axis_tlast_o,   // hull_last
  output logic               m_axis_tuser_o    // overflow
);
  logic                         q_valid, q_ready, q_last;
  logic signed [COORD_BITS-1:0] q_x, q_y;
  logic [XY_W-1:0]              hx, hy;

  cvh_front #(.CW(COORD_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tlast_i  (s_axis_tlast_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_x_o      (q_x),
    .q_y_o      (q_y),
    .q_last_o   (q_last)
  );

  cvh_back #(.MAX_POINTS(MAX_POINTS), .CW(COORD_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_x_i      (q_x),
    .q_y_i      (q_y),
    .q_last_i   (q_last),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_x_o      (hx),
    .m_y_o      (hy),
    .m_last_o   (m_axis_tlast_o),
    .m_ovf_o    (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {hy, hx};
endmodule
